>>> design/abc_pkg.sv
// ----------------------------------------------------------------------------
// abc_pkg - shared types and constants for the allocation bounds checker
// Command and result words, the token passed along the cell chain, and the
// word broadcast from the top level to every cell.
// ----------------------------------------------------------------------------
package abc_pkg;

    localparam int REGIONS   = 16;
    localparam int ADDR_BITS = 48;
    localparam int SIZE_BITS = 35;
    localparam int LEN_BITS  = SIZE_BITS - 3;
    localparam int SUM_BITS  = ADDR_BITS + 1;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CHECK  = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NO_MATCH = 2'd3;

    typedef struct packed {
        logic [1:0]           command;
        logic [ADDR_BITS-1:0] address;
        logic [SIZE_BITS-1:0] size_bits;
    } t_cmd_word;

    typedef struct packed {
        logic       safe;
        logic [1:0] status;
    } t_res_word;

    // scan token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
        logic free;
    } t_token;

    // command context seen by every cell
    typedef struct packed {
        logic [1:0]          command;
        logic [SUM_BITS-1:0] addr;
        logic [SUM_BITS-1:0] last;
        logic [LEN_BITS-1:0] bytes;
        logic                commit;
    } t_bcast;

endpackage

>>> design/allocation_bounds_checker.sv
// ----------------------------------------------------------------------------
// allocation_bounds_checker - live region table with insert, check and erase
// A command word is taken when start is high and busy is low. A scan token
// then walks a chain of REGIONS cells, one cell per cycle, and the result
// is strobed after the token leaves the last cell; busy drops in the strobe
// cycle, so the next command may be taken while the result is shown. The
// result on o_result cannot be stalled; capture it when o_strobe is high.
// ----------------------------------------------------------------------------
module allocation_bounds_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  abc_pkg::t_cmd_word i_cmd,
    output logic               o_strobe,
    output abc_pkg::t_res_word o_result
);
    import abc_pkg::*;

    logic                r_busy;
    logic                r_go;
    logic [1:0]          r_command;
    logic [SUM_BITS-1:0] r_addr;
    logic [SUM_BITS-1:0] r_last;
    logic [LEN_BITS-1:0] r_bytes;
    logic                r_strobe;
    t_res_word           r_result;
    t_res_word           n_result;

    logic                w_accept;
    logic [LEN_BITS-1:0] w_bytes;
    logic                w_commit;
    t_token              w_tok [REGIONS+1];
    t_token              w_done;
    t_bcast              w_bc;

    assign w_accept = start && !r_busy;
    assign w_bytes  = i_cmd.size_bits[SIZE_BITS-1:3];

    // capture command word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_command <= i_cmd.command;
            r_addr    <= {1'b0, i_cmd.address};
            r_last    <= {1'b0, i_cmd.address} + {{(SUM_BITS-LEN_BITS){1'b0}}, w_bytes};
            r_bytes   <= w_bytes;
        end
    end

    // control: busy from accept until the scan leaves the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_go     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_go     <= w_accept;
            r_strobe <= w_done.valid;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done.valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    // inject token into first cell
    assign w_tok[0] = '{valid: r_go, hit: 1'b0, free: 1'b0};

    genvar g;
    generate
        for (g = 0; g < REGIONS; g++) begin : g_cell
            abc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_bc    (w_bc),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign w_done = w_tok[REGIONS];

    // write the claimed slot when an insert clears all checks
    assign w_commit = w_done.valid && (r_command == CMD_INSERT) && (r_bytes != '0) &&
                      !w_done.hit && w_done.free;

    assign w_bc = '{command: r_command, addr: r_addr, last: r_last,
                    bytes: r_bytes, commit: w_commit};

    // decide result from the final token
    always_comb begin
        n_result = '{safe: 1'b0, status: ST_NO_MATCH};
        unique case (r_command)
            CMD_INSERT: begin
                priority if (r_bytes == '0 || w_done.hit) begin
                    n_result = '{safe: 1'b0, status: ST_CONFLICT};
                end else if (!w_done.free) begin
                    n_result = '{safe: 1'b0, status: ST_FULL};
                end else begin
                    n_result = '{safe: 1'b1, status: ST_OK};
                end
            end
            CMD_CHECK, CMD_ERASE: begin
                if (w_done.hit) begin
                    n_result = '{safe: 1'b1, status: ST_OK};
                end
            end
            default: n_result = '{safe: 1'b0, status: ST_NO_MATCH};
        endcase
    end

    // hold result word for the strobe cycle
    always_ff @(posedge i_clk) begin
        if (w_done.valid) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> design/abc_cell.sv
// ----------------------------------------------------------------------------
// abc_cell - one region slot of the checker chain
// Holds one region and, when the scan token passes, tests the current command
// against it and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module abc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  abc_pkg::t_bcast i_bc,
    input  abc_pkg::t_token i_tok,
    output abc_pkg::t_token o_tok
);
    import abc_pkg::*;

    logic                 r_live;
    logic [ADDR_BITS-1:0] r_base;
    logic [LEN_BITS-1:0]  r_len;
    logic                 r_claim;
    t_token               r_tok;
    t_token               n_tok;

    logic [SUM_BITS-1:0]  w_base;
    logic [SUM_BITS-1:0]  w_top;
    logic                 w_same;
    logic                 w_hit;
    logic                 w_free_here;

    // region bounds, one bit wider so nothing wraps
    assign w_base = {1'b0, r_base};
    assign w_top  = w_base + {{(SUM_BITS-LEN_BITS){1'b0}}, r_len};
    assign w_same = r_live && (w_base == i_bc.addr);

    // local test for the current command
    always_comb begin
        w_hit = 1'b0;
        unique case (i_bc.command)
            CMD_INSERT: w_hit = w_same ||
                                (r_live && (i_bc.addr < w_top) && (w_base < i_bc.last));
            CMD_CHECK:  w_hit = r_live && (w_base <= i_bc.addr) && (i_bc.last <= w_top);
            CMD_ERASE:  w_hit = w_same;
            default:    w_hit = 1'b0;
        endcase
    end

    assign w_free_here = !r_live && !i_tok.free;

    // fold local result into the token
    always_comb begin
        n_tok.valid = i_tok.valid;
        n_tok.hit   = i_tok.hit || w_hit;
        n_tok.free  = i_tok.free || !r_live;
    end

    // advance token, remember first free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_claim <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.valid) begin
                r_claim <= w_free_here;
            end
        end
    end

    // update live flag: free on erase match, set on insert commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_bc.commit && r_claim) begin
            r_live <= 1'b1;
        end else if (i_tok.valid && (i_bc.command == CMD_ERASE) && w_same) begin
            r_live <= 1'b0;
        end
    end

    // load region payload on commit
    always_ff @(posedge i_clk) begin
        if (i_bc.commit && r_claim) begin
            r_base <= i_bc.addr[ADDR_BITS-1:0];
            r_len  <= i_bc.bytes;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> bench/allocation_bounds_checker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_bounds_checker_test - self-checking bench for the region table
// Drives insert, check and erase words into the block and predicts every
// verdict with a shadow region table kept in the bench. A short directed part
// hits the edge cases: empty size, shared base, partial overlap, touching
// regions, zero-length checks, top-of-space spans, a full table and unused
// commands. A random part follows, built around a moving address window.
// ----------------------------------------------------------------------------
module allocation_bounds_checker_test;
    import abc_pkg::*;

    // command code with no defined operation
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        t_cmd_word word;
        bit        drain_first;
    } t_queued_cmd;

    typedef struct {
        logic [ADDR_BITS-1:0] base;
        logic [LEN_BITS-1:0]  nbytes;
    } t_region;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_cmd_word cmd_word = '0;
    logic      o_strobe;
    t_res_word o_result;

    // shadow of the block's region table
    logic [ADDR_BITS-1:0] shadow_base [REGIONS];
    logic [LEN_BITS-1:0]  shadow_len  [REGIONS];
    logic                 shadow_live [REGIONS] = '{default: 1'b0};

    t_queued_cmd queued_commands [$];
    t_res_word   pending_verdicts [$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          in_flight = 0;
    int          status_tally [4] = '{default: 0};

    allocation_bounds_checker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_word),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Work out the verdict of one command word and update the shadow table.
    function automatic t_res_word judge_command(t_cmd_word w);
        t_res_word           r;
        logic [LEN_BITS-1:0] nbytes;
        logic [SUM_BITS-1:0] lo, hi, rb, re;
        int                  slot;
        bit                  clash;
        nbytes = w.size_bits[SIZE_BITS-1:3];
        lo = {1'b0, w.address};
        hi = lo + SUM_BITS'(nbytes);
        r.safe = 1'b0;
        r.status = ST_NO_MATCH;
        slot = -1;
        clash = 1'b0;
        case (w.command)
            CMD_INSERT: begin
                if (nbytes == '0) begin
                    r.status = ST_CONFLICT;
                end else begin
                    for (int i = 0; i < REGIONS; i++) begin
                        if (shadow_live[i]) begin
                            rb = {1'b0, shadow_base[i]};
                            re = rb + SUM_BITS'(shadow_len[i]);
                            if (rb == lo || (lo < re && rb < hi)) clash = 1'b1;
                        end else if (slot < 0) begin
                            slot = i;
                        end
                    end
                    if (clash) begin
                        r.status = ST_CONFLICT;
                    end else if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        shadow_base[slot] = w.address;
                        shadow_len[slot]  = nbytes;
                        shadow_live[slot] = 1'b1;
                        r.safe = 1'b1;
                        r.status = ST_OK;
                    end
                end
            end
            CMD_CHECK: begin
                for (int i = 0; i < REGIONS; i++) begin
                    if (shadow_live[i]) begin
                        rb = {1'b0, shadow_base[i]};
                        re = rb + SUM_BITS'(shadow_len[i]);
                        if (rb <= lo && hi <= re) begin
                            r.safe = 1'b1;
                            r.status = ST_OK;
                        end
                    end
                end
            end
            CMD_ERASE: begin
                for (int i = 0; i < REGIONS; i++) begin
                    if (slot < 0 && shadow_live[i] && shadow_base[i] == w.address) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    shadow_live[slot] = 1'b0;
                    r.safe = 1'b1;
                    r.status = ST_OK;
                end
            end
            default: begin
                // unused code: no state change, no match
            end
        endcase
        return r;
    endfunction

    // Append one command word to the stimulus queue.
    task automatic queue_word(logic [1:0] cmd, logic [ADDR_BITS-1:0] addr,
                              logic [SIZE_BITS-1:0] sbits, bit drain = 1'b0);
        t_queued_cmd q;
        q.word.command   = cmd;
        q.word.address   = addr;
        q.word.size_bits = sbits;
        q.drain_first    = drain;
        queued_commands.push_back(q);
    endtask

    // Byte count to a size in bits, with random truncated low bits.
    function automatic logic [SIZE_BITS-1:0] bits_of(logic [LEN_BITS-1:0] nbytes);
        return {nbytes, 3'($urandom_range(0, 7))};
    endfunction

    // Driver: offer the next word, hold it until taken, idle at random.
    always @(posedge i_clk) begin
        t_queued_cmd nxt;
        logic        idle_now;
        if (!i_rst_n) begin
            start <= 1'b0;
            in_flight = 0;
        end else begin
            if (start && !busy) begin
                pending_verdicts.push_back(judge_command(cmd_word));
                words_sent++;
                in_flight++;
            end
            if (o_strobe) in_flight--;
            idle_now = (words_sent < 300 || words_sent >= 520)
                       && ($urandom_range(0, 99) < 17);
            if (start && busy) begin
                // hold the offered word
            end else if (queued_commands.size() > 0 && !idle_now
                         && (!queued_commands[0].drain_first || in_flight == 0)) begin
                nxt = queued_commands.pop_front();
                cmd_word <= nxt.word;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expected verdict.
    always @(posedge i_clk) begin
        t_res_word want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: safe %0d status %0d",
                       o_result.safe, o_result.status);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                status_tally[want.status]++;
                if (o_result.safe !== want.safe) begin
                    $error("safe mismatch: expected %0d, got %0d", want.safe, o_result.safe);
                    mismatch_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, o_result.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Limit the run.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_region              known [$];
        t_region              reg_pick;
        logic [ADDR_BITS-1:0] window;
        logic [ADDR_BITS-1:0] addr;
        logic [LEN_BITS-1:0]  nbytes;
        int unsigned          pick, idx, lim, off;

        // directed: basic insert, empty size, shared base, partial overlap
        queue_word(CMD_INSERT, 48'h1000, bits_of(32'd256));
        queue_word(CMD_INSERT, 48'h5000, 35'd7);
        queue_word(CMD_INSERT, 48'h1000, bits_of(32'd16));
        queue_word(CMD_INSERT, 48'h10F0, bits_of(32'h20));
        // touching region is no overlap
        queue_word(CMD_INSERT, 48'h1100, bits_of(32'h10));
        queue_word(CMD_CHECK, 48'h1000, bits_of(32'd256));
        // span across two regions fails
        queue_word(CMD_CHECK, 48'h10FF, bits_of(32'd2));
        // zero-length check at the end of a region passes
        queue_word(CMD_CHECK, 48'h1110, bits_of(32'd0));
        queue_word(CMD_CHECK, 48'h0FFF, bits_of(32'd1));
        // top of the address space with the largest size
        queue_word(CMD_INSERT, {ADDR_BITS{1'b1}}, {SIZE_BITS{1'b1}});
        queue_word(CMD_CHECK, {ADDR_BITS{1'b1}}, bits_of(32'd1));
        // fill the table, then one more insert
        for (int k = 0; k < 13; k++) begin
            queue_word(CMD_INSERT, 48'(k) << 16, bits_of(32'd16));
            known.push_back('{base: 48'(k) << 16, nbytes: 32'd16});
        end
        queue_word(CMD_INSERT, 48'h20_0000, bits_of(32'd1));
        queue_word(CMD_ERASE, 48'h5000, {SIZE_BITS{1'b1}});
        queue_word(CMD_ERASE, {ADDR_BITS{1'b1}}, '0);
        queue_word(CMD_SPARE, 48'h1000, bits_of(32'd4));
        known.push_back('{base: 48'h1000, nbytes: 32'd256});
        known.push_back('{base: 48'h1100, nbytes: 32'h10});

        // random: inserts, checks and erases clustered in a moving window
        window = '0;
        for (int n = 0; n < 920; n++) begin
            if (n % 150 == 0) window = {16'($urandom), 32'($urandom)} & ~48'h3FFF;
            if (n == 600) window = 48'hFFFF_FFFF_C000;
            pick = $urandom_range(0, 99);
            if (pick < 33) begin
                addr = window + 48'($urandom_range(0, 1023));
                nbytes = ($urandom_range(0, 19) == 0) ? 32'($urandom)
                                                       : 32'($urandom_range(0, 64));
                queue_word(CMD_INSERT, addr, bits_of(nbytes), n % 200 == 0);
                if (nbytes != 0) known.push_back('{base: addr, nbytes: nbytes});
            end else if (pick < 63) begin
                if (known.size() == 0) begin
                    queue_word(CMD_CHECK, window + 48'($urandom_range(0, 1023)),
                               bits_of(32'($urandom_range(0, 8))), n % 200 == 0);
                end else begin
                    reg_pick = known[$urandom_range(0, known.size() - 1)];
                    lim = (reg_pick.nbytes > 4096) ? 4096 : reg_pick.nbytes;
                    off = $urandom_range(0, lim);
                    queue_word(CMD_CHECK, reg_pick.base + 48'(off),
                               bits_of(32'($urandom_range(0, lim - off + 2))), n % 200 == 0);
                end
            end else if (pick < 93) begin
                if (known.size() > 0 && $urandom_range(0, 99) < 85) begin
                    idx = $urandom_range(0, known.size() - 1);
                    addr = known[idx].base;
                    known.delete(idx);
                end else begin
                    addr = window + 48'($urandom_range(0, 1023));
                end
                queue_word(CMD_ERASE, addr, {3'($urandom), 32'($urandom)}, n % 200 == 0);
            end else begin
                // noise: any command, any address, any size
                queue_word(2'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)},
                           {3'($urandom), 32'($urandom)}, n % 200 == 0);
            end
        end

        // release reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all words to be taken and all verdicts to arrive
        while (queued_commands.size() != 0 || start) @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (REGIONS + 8) @(posedge i_clk);

        $display("Run covered %0d command words and %0d results.", words_sent, results_seen);
        $display("Verdicts: ok %0d, conflict or empty %0d, table full %0d, no match %0d.",
                 status_tally[ST_OK], status_tally[ST_CONFLICT],
                 status_tally[ST_FULL], status_tally[ST_NO_MATCH]);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/abc_pkg.sv
design/abc_cell.sv
design/allocation_bounds_checker.sv
bench/allocation_bounds_checker_test.sv
